/* hdl/aab_pkg.sv */
// shared types, constants and helpers for the argb alpha blend pipeline
`timescale 1ns / 1ps

package aab_pkg;

  localparam int PixW      = 32;
  localparam int ChW       = 8;
  localparam int NumCh     = 3;
  localparam int NumStages = 11;
  localparam int DivStages = 4;

  localparam logic [ChW-1:0] ChMax     = 8'hFF;
  localparam logic [ChW-1:0] GaReset   = 8'hFF;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_KEEP  = 2'd0;
  localparam mode_t MODE_COPY  = 2'd1;
  localparam mode_t MODE_BLEND = 2'd2;

  typedef struct packed {
    logic [16:0]    rem;
    logic [ChW-1:0] q;
    logic           sat;
  } div_lane_t;

  typedef struct packed {
    mode_t                      mode;
    logic [PixW-1:0]            pass;
    logic [ChW-1:0]             oa;
    div_lane_t [NumCh-1:0]      lane;
  } div_stage_t;

  // floor(x / 255) for x below 255 * 2^16 (16-bit result), estimate plus one correction
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [24:0] sum;
    logic [24:0] q0;
    logic [24:0] r;
    sum = {1'b0, x} + {9'd0, x[23:8]} + {17'd0, x[23:16]};
    q0  = {8'd0, sum[24:8]};
    r   = {1'b0, x} - ((q0 << 8) - q0);
    if (r >= 25'd255) begin
      q0 = q0 + 25'd1;
    end
    return q0[15:0];
  endfunction

  // two restoring division steps, quotient bits hi and hi-1
  function automatic div_lane_t div_step2(input div_lane_t ln, input logic [ChW-1:0] oa,
                                          input logic [2:0] hi);
    div_lane_t   r;
    logic [16:0] dvs;
    logic [2:0]  b;
    r = ln;
    for (int i = 0; i < 2; i++) begin
      b   = hi - 3'(i);
      dvs = {9'd0, oa} << b;
      if (r.rem >= dvs) begin
        r.rem  = r.rem - dvs;
        r.q[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* hdl/argb_alpha_blend.sv */
// argb8888 source-over blend with layer opacity, eleven-stage pipeline
// throughput: one item per cycle while out_stall is low; the per-stage ready chain fills bubbles under stall
// the 8-bit quotient per colour channel comes from four stages of 2-bit restoring division
// reset (rst, synchronous): clears all stage valid bits, layer_alpha returns to 255
`timescale 1ns / 1ps

module argb_alpha_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [aab_pkg::ChW-1:0]     cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aab_pkg::PixW-1:0]    src_argb,
  input  logic [aab_pkg::PixW-1:0]    dst_argb,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aab_pkg::PixW-1:0]    out_pixel,
  output logic                        write_enable
);
  import aab_pkg::*;

  logic [ChW-1:0]       layer_alpha;
  logic [NumStages:1]   v;
  logic [NumStages:1]   rdy;

  // stage 1
  logic [PixW-1:0]      s1_src, s1_dest;
  logic [15:0]          s1_prod;
  // stage 2
  logic [ChW-1:0]       s2_ea;
  mode_t                s2_mode;
  logic [PixW-1:0]      s2_pass;
  logic [23:0]          s2_src;
  logic [PixW-1:0]      s2_dest;
  logic [ChW-1:0]       ea_next;
  // stage 3
  logic [ChW-1:0]       s3_ea;
  mode_t                s3_mode;
  logic [PixW-1:0]      s3_pass;
  logic [23:0]          s3_dest;
  logic [15:0]          s3_t;
  logic [NumCh-1:0][15:0] s3_sea;
  // stage 4
  logic [ChW-1:0]       s4_oa;
  mode_t                s4_mode;
  logic [PixW-1:0]      s4_pass;
  logic [NumCh-1:0][15:0] s4_sea;
  logic [NumCh-1:0][23:0] s4_dt;
  // stage 5
  logic [ChW-1:0]       s5_oa;
  mode_t                s5_mode;
  logic [PixW-1:0]      s5_pass;
  logic [NumCh-1:0][15:0] s5_sea;
  logic [NumCh-1:0][15:0] s5_dq;
  // stage 6 and divider stages 7 to 10
  div_stage_t           s6;
  div_stage_t           s6_next;
  div_stage_t           dv      [DivStages];
  div_stage_t           dv_next [DivStages];
  logic [PixW-1:0]      pix_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = !rdy[1];
  assign out_valid = v[NumStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_alpha <= GaReset;
    end else if (cfg_valid && cfg_ready) begin
      layer_alpha <= cfg_data;
    end
  end

  always_comb begin
    rdy[NumStages] = !v[NumStages] || !out_stall;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign ea_next = ChW'(div255({8'd0, s1_prod}));

  always_comb begin
    s6_next.mode = s5_mode;
    s6_next.pass = s5_pass;
    s6_next.oa   = s5_oa;
    for (int c = 0; c < NumCh; c++) begin
      s6_next.lane[c].rem = {1'b0, s5_sea[c]} + {1'b0, s5_dq[c]};
      s6_next.lane[c].q   = '0;
      s6_next.lane[c].sat = ({1'b0, s5_sea[c]} + {1'b0, s5_dq[c]}) >= {1'b0, s5_oa, 8'd0};
    end
  end

  always_comb begin
    for (int j = 0; j < DivStages; j++) begin
      dv_next[j] = (j == 0) ? s6 : dv[(j == 0) ? 0 : j - 1];
      for (int c = 0; c < NumCh; c++) begin
        dv_next[j].lane[c] = div_step2((j == 0) ? s6.lane[c] : dv[(j == 0) ? 0 : j - 1].lane[c],
                                       dv_next[j].oa, 3'(7 - 2 * j));
      end
    end
  end

  always_comb begin
    pix_next = dv[DivStages-1].pass;
    if (dv[DivStages-1].mode == MODE_BLEND) begin
      pix_next[PixW-1 -: ChW] = dv[DivStages-1].oa;
      for (int c = 0; c < NumCh; c++) begin
        pix_next[ChW*c +: ChW] = dv[DivStages-1].lane[c].sat ? ChMax : dv[DivStages-1].lane[c].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_src  <= src_argb;
      s1_dest <= dst_argb;
      s1_prod <= 16'(src_argb[PixW-1 -: ChW]) * 16'(layer_alpha);
    end
    if (rdy[2]) begin
      s2_ea   <= ea_next;
      s2_src  <= s1_src[23:0];
      s2_dest <= s1_dest;
      if (ea_next == '0) begin
        s2_mode <= MODE_KEEP;
        s2_pass <= s1_dest;
      end else if (ea_next == ChMax) begin
        s2_mode <= MODE_COPY;
        s2_pass <= s1_src;
      end else begin
        s2_mode <= MODE_BLEND;
        s2_pass <= s1_dest;
      end
    end
    if (rdy[3]) begin
      s3_ea   <= s2_ea;
      s3_mode <= s2_mode;
      s3_pass <= s2_pass;
      s3_dest <= s2_dest[23:0];
      s3_t    <= 16'(s2_dest[PixW-1 -: ChW]) * 16'(ChMax - s2_ea);
      for (int c = 0; c < NumCh; c++) begin
        s3_sea[c] <= 16'(s2_src[ChW*c +: ChW]) * 16'(s2_ea);
      end
    end
    if (rdy[4]) begin
      s4_oa   <= s3_ea + ChW'(div255({8'd0, s3_t}));
      s4_mode <= s3_mode;
      s4_pass <= s3_pass;
      s4_sea  <= s3_sea;
      for (int c = 0; c < NumCh; c++) begin
        s4_dt[c] <= 24'(s3_dest[ChW*c +: ChW]) * 24'(s3_t);
      end
    end
    if (rdy[5]) begin
      s5_oa   <= s4_oa;
      s5_mode <= s4_mode;
      s5_pass <= s4_pass;
      s5_sea  <= s4_sea;
      for (int c = 0; c < NumCh; c++) begin
        s5_dq[c] <= div255(s4_dt[c]);
      end
    end
    if (rdy[6]) begin
      s6 <= s6_next;
    end
    for (int j = 0; j < DivStages; j++) begin
      if (rdy[7 + j]) begin
        dv[j] <= dv_next[j];
      end
    end
    if (rdy[NumStages]) begin
      out_pixel    <= pix_next;
      write_enable <= (dv[DivStages-1].mode != MODE_KEEP);
    end
  end

  // input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // any write carries a nonzero alpha
  a_write_alpha: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> (out_pixel[PixW-1 -: ChW] != '0))
    else $error("write with zero output alpha");

  // a result taken with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v[NumStages-1]) |=> !out_valid)
    else $error("result repeated at output");

endmodule

/* verif/argb_alpha_blend_tb.sv */
// testbench for argb_alpha_blend: directed and random pixels checked against a blend predictor
`timescale 1ns / 1ps

module argb_alpha_blend_tb;

  import aab_pkg::*;

  localparam int unsigned FullAlpha = 255;
  localparam int ItemsPerPhase = 119;
  localparam int NumPhases = 8;
  localparam int StallLimit = 5000;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            wr;
  } blend_res_t;

  class blend_scoreboard;
    logic [ChW-1:0] opacity;
    blend_res_t     expected_q[$];
    int unsigned    n_checked;
    int unsigned    n_written;
    int unsigned    n_errors;

    function new();
      opacity   = GaReset;
      n_checked = 0;
      n_written = 0;
      n_errors  = 0;
    endfunction

    function void set_opacity(logic [ChW-1:0] v);
      opacity = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function blend_res_t blend_pixel(logic [PixW-1:0] s, logic [PixW-1:0] d);
      blend_res_t  r;
      int unsigned sa, ga, ea, da, oa, sc, dc, num, q;
      r.pixel = d;
      r.wr    = 1'b0;
      sa = 32'(s[31:24]);
      ga = 32'(opacity);
      ea = sa * ga / FullAlpha;
      if (ea == 0) begin
        return r;
      end
      if (ea == FullAlpha) begin
        r.pixel = s;
        r.wr    = 1'b1;
        return r;
      end
      da = 32'(d[31:24]);
      oa = ea + da * (FullAlpha - ea) / FullAlpha;
      if (oa == 0) begin
        return r;
      end
      for (int c = 0; c < NumCh; c++) begin
        sc  = 32'(s[c*ChW +: ChW]);
        dc  = 32'(d[c*ChW +: ChW]);
        num = sc * ea + dc * da * (FullAlpha - ea) / FullAlpha;
        q   = num / oa;
        if (q > FullAlpha) begin
          q = FullAlpha;
        end
        r.pixel[c*ChW +: ChW] = q[ChW-1:0];
      end
      r.pixel[31:24] = oa[ChW-1:0];
      r.wr = 1'b1;
      return r;
    endfunction

    function void note_pixel(logic [PixW-1:0] s, logic [PixW-1:0] d);
      expected_q.push_back(blend_pixel(s, d));
    endfunction

    function void check_pixel(logic [PixW-1:0] px, logic wr);
      blend_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item out_pixel=%h write_enable=%b", $time, px, wr);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (wr) begin
        n_written++;
      end
      if (px !== e.pixel) begin
        $display("%0t: out_pixel expected %h actual %h", $time, e.pixel, px);
        n_errors++;
      end
      if (wr !== e.wr) begin
        $display("%0t: write_enable expected %b actual %b", $time, e.wr, wr);
        n_errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ChW-1:0]  cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [PixW-1:0] src_argb = '0;
  logic [PixW-1:0] dst_argb = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [PixW-1:0] out_pixel;
  logic            write_enable;

  blend_scoreboard sb = new();
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;

  logic [PixW-1:0] dir_src [16] = '{
    32'h00123456, 32'hFF123456, 32'hFFFFFFFF, 32'h00000000,
    32'h01FFFFFF, 32'h80FFFFFF, 32'h80000000, 32'hFEFFFFFF,
    32'h01000000, 32'hAA55AA55, 32'h55AA55AA, 32'h7F808080,
    32'h01FFFFFF, 32'hFE000000, 32'h40FF00FF, 32'h02FFFFFF
  };
  logic [PixW-1:0] dir_dest [16] = '{
    32'hFFABCDEF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000,
    32'h01FFFFFF, 32'hFF000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'h00FFFFFF, 32'h55AA55AA, 32'hAA55AA55, 32'h807F7F7F,
    32'hFFFFFFFF, 32'h01FFFFFF, 32'hC000FF00, 32'h02FFFFFF
  };

  argb_alpha_blend dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .src_argb     (src_argb),
    .dst_argb     (dst_argb),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .write_enable (write_enable)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // handshakes sampled at the edge, before any update of this step lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_opacity(cfg_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_pixel(src_argb, dst_argb);
      end
      if (out_valid && !out_stall) begin
        sb.check_pixel(out_pixel, write_enable);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] s, input logic [PixW-1:0] d);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    src_argb <= s;
    dst_argb <= d;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (NumStages + 2) @(posedge clk);
  endtask

  task automatic write_opacity(input logic [ChW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] p;
    p = $urandom();
    case ($urandom_range(0, 7))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      2: p[31:24] = 8'($urandom_range(1, 3));
      3: p[23:0] = 24'hFFFFFF;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [ChW-1:0] opacity_list [NumPhases];
    opacity_list = '{8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80, 8'($urandom), 8'h25, 8'($urandom)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset opacity first, so the default register value is exercised
    for (int i = 0; i < 16; i++) begin
      send_pixel(dir_src[i], dir_dest[i]);
    end
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_opacity(opacity_list[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_pixel(rand_pixel(), rand_pixel());
      end
      wait_idle();
    end

    $display("run covered %0d pixels over %0d opacity settings and four idle mixes",
             sb.n_checked, NumPhases + 1);
    $display("%0d pixels written, %0d left unchanged",
             sb.n_written, sb.n_checked - sb.n_written);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, sb.pending());
    end
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/aab_pkg.sv
hdl/argb_alpha_blend.sv
verif/argb_alpha_blend_tb.sv
